// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every rising edge of i_clk, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/lqfl_pkg.sv =====
// ---------------------------------------------------------------------------
// lqfl_pkg
// Types and constants of the linked queue with free list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lqfl_pkg;

    localparam int NODE_COUNT_DEF = 8;
    localparam int DATA_W         = 32;
    localparam int STATUS_W       = 2;

    // operation codes on the input tuser bit
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0]   removed_value;
        logic [DATA_W-1:0]   front_value;
        logic [DATA_W-1:0]   rear_value;
        logic [STATUS_W-1:0] status;
        logic                is_empty;
        logic                is_full;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/lqfl_ram.sv =====
// ---------------------------------------------------------------------------
// lqfl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/lqfl_core.sv =====
// ---------------------------------------------------------------------------
// lqfl_core
// List pointers, free-list allocator and idle/busy operation sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lqfl_core #(
    parameter int NODE_COUNT = lqfl_pkg::NODE_COUNT_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // operation request
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic                                   i_func,
    input  wire logic [lqfl_pkg::DATA_W-1:0]            i_value,
    // result towards the output register
    input  wire logic                                   i_out_free,
    output logic                                        o_res_valid,
    output lqfl_pkg::t_result                           o_res,
    // node store port
    output logic                                        o_rd_en,
    output logic [$clog2(NODE_COUNT)-1:0]               o_rd_addr,
    output logic                                        o_wr_en,
    output logic [$clog2(NODE_COUNT)-1:0]               o_wr_addr,
    output logic [$clog2(NODE_COUNT+1)+lqfl_pkg::DATA_W-1:0] o_wr_data,
    input  wire logic [$clog2(NODE_COUNT+1)+lqfl_pkg::DATA_W-1:0] i_rd_data
);

    import lqfl_pkg::*;

    localparam int IDX_W   = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int ENTRY_W = IDX_W + DATA_W;
    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(NODE_COUNT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic              r_state, n_state;
    logic              r_func;
    logic [DATA_W-1:0] r_value;
    logic [IDX_W-1:0]  r_free_head, n_free_head;
    logic [IDX_W-1:0]  r_fresh, n_fresh;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [IDX_W-1:0]  r_rear, n_rear;
    logic [DATA_W-1:0] r_front_val, n_front_val;
    logic [DATA_W-1:0] r_rear_val, n_rear_val;

    logic              w_accept;
    logic              w_commit;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [IDX_W-1:0]  w_link;
    logic [DATA_W-1:0] w_next_val;
    logic              w_empty;
    logic              w_full;
    logic [IDX_W-1:0]  w_wr_idx;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_commit = (r_state == ST_BUSY) && i_out_free;

    // Enqueue looks up the successor of the free head, dequeue the front entry
    assign w_rd_idx  = (i_func == FUNC_ENQ) ? r_free_head : r_front;
    assign o_rd_en   = w_accept && (w_rd_idx != NULL_IDX);
    assign o_rd_addr = w_rd_idx[ADDR_W-1:0];

    // Each entry holds its link and the value of the node it links to
    assign w_link     = i_rd_data[ENTRY_W-1:DATA_W];
    assign w_next_val = i_rd_data[DATA_W-1:0];

    assign w_empty = (r_front == NULL_IDX);
    assign w_full  = (r_free_head == NULL_IDX);

    assign o_wr_addr = w_wr_idx[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        n_front     = r_front;
        n_rear      = r_rear;
        n_front_val = r_front_val;
        n_rear_val  = r_rear_val;
        o_wr_en     = 1'b0;
        w_wr_idx    = r_rear;
        o_wr_data   = {r_free_head, r_value};
        o_res_valid = 1'b0;
        o_res.removed_value = '0;
        o_res.status        = STATUS_DONE;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_commit) begin
                    n_state     = ST_IDLE;
                    o_res_valid = 1'b1;
                    if (r_func == FUNC_ENQ) begin
                        if (w_full) begin
                            o_res.status = STATUS_FULL;
                        end else begin
                            // nodes at or above the fill mark still chain in order
                            if (r_free_head == r_fresh) begin
                                n_free_head = r_fresh + IDX_W'(1);
                                n_fresh     = r_fresh + IDX_W'(1);
                            end else begin
                                n_free_head = w_link;
                            end
                            if (w_empty) begin
                                n_front     = r_free_head;
                                n_front_val = r_value;
                            end else begin
                                o_wr_en   = 1'b1;
                                w_wr_idx  = r_rear;
                                o_wr_data = {r_free_head, r_value};
                            end
                            n_rear     = r_free_head;
                            n_rear_val = r_value;
                        end
                    end else begin
                        if (w_empty) begin
                            o_res.status = STATUS_EMPTY;
                        end else begin
                            o_res.removed_value = r_front_val;
                            o_wr_en     = 1'b1;
                            w_wr_idx    = r_front;
                            o_wr_data   = {r_free_head, DATA_W'(0)};
                            n_free_head = r_front;
                            if (r_front == r_rear) begin
                                n_front     = NULL_IDX;
                                n_rear      = NULL_IDX;
                                n_front_val = '0;
                                n_rear_val  = '0;
                            end else begin
                                n_front     = w_link;
                                n_front_val = w_next_val;
                            end
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        o_res.front_value = n_front_val;
        o_res.rear_value  = n_rear_val;
        o_res.is_empty    = (n_front == NULL_IDX);
        o_res.is_full     = (n_free_head == NULL_IDX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_front     <= NULL_IDX;
            r_rear      <= NULL_IDX;
            r_front_val <= '0;
            r_rear_val  <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_front_val <= n_front_val;
            r_rear_val  <= n_rear_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= i_func;
            r_value <= i_value;
        end
    end

endmodule

`default_nettype wire

// ===== sv/linked_queue_with_free_list.sv =====
// ---------------------------------------------------------------------------
// linked_queue_with_free_list
// FIFO queue kept as a linked list in a node RAM, unused nodes on a free list.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                               tuser
//  s_axis   in   value[31:0]                         func (0 enqueue, 1 dequeue)
//  m_axis   out  removed, front, rear (32 b each)    status[1:0], is_empty, is_full
//
//  In the accept cycle a word reads the node RAM; in the busy state that follows,
//  the block writes the RAM back and loads the result, as the RAM read is registered.
//  No clearing pass after reset: a fill mark tracks nodes never yet used.
//  A new word is accepted while a result waits; a stalled output holds the
//  finished operation in the busy state until the result register empties.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module linked_queue_with_free_list #(
    parameter int NODE_COUNT = lqfl_pkg::NODE_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [lqfl_pkg::DATA_W-1:0]   i_s_axis_tdata,  // value
    input  wire logic                          i_s_axis_tuser,  // func
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [3*lqfl_pkg::DATA_W-1:0]      o_m_axis_tdata,  // removed, front, rear
    output logic [lqfl_pkg::STATUS_W+1:0]      o_m_axis_tuser   // status, is_empty, is_full
);

    import lqfl_pkg::*;

    localparam int IDX_W   = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int ENTRY_W = IDX_W + DATA_W;

    logic               w_res_valid;
    t_result            w_res;
    logic               w_out_free;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [ENTRY_W-1:0] w_rd_data;

    logic               r_out_valid;
    t_result            r_out;

    // the result register frees up when empty or drained this cycle
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    lqfl_core #(
        .NODE_COUNT (NODE_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_func      (i_s_axis_tuser),
        .i_value     (i_s_axis_tdata),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .i_rd_data   (w_rd_data)
    );

    // node store: link and successor value per node
    lqfl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // result register: load on completion, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.rear_value, r_out.front_value, r_out.removed_value};
    assign o_m_axis_tuser  = {r_out.is_full, r_out.is_empty, r_out.status};

    // never overwrite a result that has not been taken
    `ASSERT_CLK(a_no_overwrite, w_res_valid |-> w_out_free, "result register overwritten")
    // an accepted word leaves the sequencer busy, not ready for another word
    `ASSERT_CLK(a_busy_after_accept, (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready,
        "word accepted while busy")
    // a completed operation is presented on the next cycle
    `ASSERT_CLK(a_result_shown, w_res_valid |=> o_m_axis_tvalid, "result not presented")
    // a completed result never reports the queue both empty and full
    `ASSERT_ALWAYS(a_empty_not_full, w_res_valid |-> !(w_res.is_empty && w_res.is_full),
        "queue both empty and full")

endmodule

`default_nettype wire

// ===== sim/tb_linked_queue_with_free_list.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_linked_queue_with_free_list
// Self-checking bench for the linked queue with free list. A directed
// opening covers the empty and full corners, value extremes and ignored
// dequeue values. Random runs of enqueue-heavy, balanced and dequeue-heavy words then
// follow. Each accepted word goes through an internal copy of the node
// store, and every result word is checked against the expected result.
// ---------------------------------------------------------------------------
module tb_linked_queue_with_free_list;
    import lqfl_pkg::*;

    localparam int         NODES        = NODE_COUNT_DEF;
    localparam logic [3:0] NIL          = 4'(NODES);  // null link, one past the last node
    localparam int         RANDOM_WORDS = 1400;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         MAX_REPORTS  = 10;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         TAIL_CYCLES  = 20;

    typedef struct {
        logic              func;
        logic [DATA_W-1:0] value;
        bit                settle;  // hold this word back until every result is in
    } t_op_word;

    // clock, reset and block ports
    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [DATA_W-1:0]        i_s_axis_tdata  = '0;   // value
    logic                     i_s_axis_tuser  = 1'b0; // func
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [3*DATA_W-1:0]      o_m_axis_tdata;         // removed, front, rear
    logic [STATUS_W+1:0]      o_m_axis_tuser;         // status, is_empty, is_full

    // queue shadow: node store, links and the three pointers
    logic [DATA_W-1:0] node_val  [NODES];
    logic [3:0]        node_next [NODES];
    logic [3:0]        free_ptr;
    logic [3:0]        front_ptr;
    logic [3:0]        rear_ptr;

    t_op_word pending_words [$];
    t_result  exp_results   [$];

    int accepted_cnt = 0;
    int result_cnt   = 0;
    int fails        = 0;
    int cycle_cnt    = 0;
    int n_enq        = 0;
    int n_deq        = 0;
    int n_full       = 0;
    int n_empty      = 0;
    int tx_wait      = 0;
    int tx_burst     = 0;
    int rx_wait      = 0;
    int rx_burst     = 0;
    int hold_left    = 0;
    int holds_done   = 0;
    t_op_word tx_word;
    t_result  got_res;
    t_result  want_res;

    linked_queue_with_free_list #(
        .NODE_COUNT (NODES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Chain every node on the free list, leave the queue empty.
    function automatic void clear_queue_shadow();
        for (int i = 0; i < NODES; i++) begin
            node_val[i]  = '0;
            node_next[i] = 4'(i + 1);
        end
        free_ptr  = '0;
        front_ptr = NIL;
        rear_ptr  = NIL;
    endfunction

    // Apply one word to the shadow queue and return the result it should give.
    function automatic t_result apply_queue_op(input logic func,
                                               input logic [DATA_W-1:0] value);
        t_result    r;
        logic [3:0] n;
        r        = '0;
        r.status = STATUS_DONE;
        if (func == FUNC_ENQ) begin
            n = free_ptr;
            if (n != NIL) begin
                free_ptr     = node_next[n];
                node_val[n]  = value;
                node_next[n] = NIL;
                // link behind the rear, or start a fresh queue
                if (front_ptr != NIL && rear_ptr != NIL)
                    node_next[rear_ptr] = n;
                else
                    front_ptr = n;
                rear_ptr = n;
                n_enq++;
            end else begin
                r.status = STATUS_FULL;
                n_full++;
            end
        end else begin
            n = front_ptr;
            if (n != NIL) begin
                r.removed_value = node_val[n];
                front_ptr       = node_next[n];
                node_next[n]    = free_ptr;
                free_ptr        = n;
                if (front_ptr == NIL)
                    rear_ptr = NIL;
                n_deq++;
            end else begin
                r.status = STATUS_EMPTY;
                n_empty++;
            end
        end
        r.front_value = (front_ptr != NIL) ? node_val[front_ptr] : '0;
        r.rear_value  = (rear_ptr  != NIL) ? node_val[rear_ptr]  : '0;
        r.is_empty    = (front_ptr == NIL);
        r.is_full     = (free_ptr  == NIL);
        return r;
    endfunction

    function automatic void add_word(input logic func, input logic [DATA_W-1:0] value,
                                     input bit settle);
        t_op_word w;
        w.func   = func;
        w.value  = value;
        w.settle = settle;
        pending_words.push_back(w);
    endfunction

    // Sender: predict on acceptance, then offer the next queued word after
    // its drawn wait. A word marked settle stays back until the pipe is dry.
    always @(posedge i_clk) begin : drive_words
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tuser  <= FUNC_ENQ;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                exp_results.push_back(apply_queue_op(i_s_axis_tuser, i_s_axis_tdata));
                accepted_cnt++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0 &&
                             !(pending_words[0].settle && accepted_cnt != result_cnt)) begin
                    tx_word = pending_words.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= tx_word.value;
                    i_s_axis_tuser  <= tx_word.func;
                    // draw the wait before the next word; bursts run with none
                    if (tx_burst > 0) begin
                        tx_burst--;
                        tx_wait = 0;
                    end else begin
                        tx_wait = $urandom_range(0, 11);
                        if ($urandom_range(0, 15) == 0)
                            tx_burst = $urandom_range(15, 60);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs: stall the output so the block backs up and
    // drops tready on its input while the sender keeps offering.
    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && accepted_cnt >= 150 + holds_done * 550) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Receiver: check each result word against the oldest expectation, then
    // draw how long to wait before taking the next one.
    always @(posedge i_clk) begin : watch_results
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_res.removed_value = o_m_axis_tdata[DATA_W-1:0];
                got_res.front_value   = o_m_axis_tdata[2*DATA_W-1:DATA_W];
                got_res.rear_value    = o_m_axis_tdata[3*DATA_W-1:2*DATA_W];
                got_res.status        = o_m_axis_tuser[STATUS_W-1:0];
                got_res.is_empty      = o_m_axis_tuser[STATUS_W];
                got_res.is_full       = o_m_axis_tuser[STATUS_W+1];
                result_cnt++;
                if (exp_results.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("[%0t] result word %0d arrived with nothing expected",
                                 $realtime, result_cnt);
                end else begin
                    want_res = exp_results.pop_front();
                    if (got_res.removed_value !== want_res.removed_value ||
                        got_res.front_value   !== want_res.front_value   ||
                        got_res.rear_value    !== want_res.rear_value    ||
                        got_res.status        !== want_res.status        ||
                        got_res.is_empty      !== want_res.is_empty      ||
                        got_res.is_full       !== want_res.is_full) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display("[%0t] result %0d mismatch", $realtime, result_cnt);
                            $display("  exp removed=%h front=%h rear=%h status=%0d empty=%b full=%b",
                                     want_res.removed_value, want_res.front_value,
                                     want_res.rear_value, want_res.status,
                                     want_res.is_empty, want_res.is_full);
                            $display("  got removed=%h front=%h rear=%h status=%0d empty=%b full=%b",
                                     got_res.removed_value, got_res.front_value,
                                     got_res.rear_value, got_res.status,
                                     got_res.is_empty, got_res.is_full);
                        end
                    end
                end
                if (rx_burst > 0) begin
                    rx_burst--;
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, 11);
                    if ($urandom_range(0, 15) == 0)
                        rx_burst = $urandom_range(15, 60);
                end
            end
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d words in, %0d results out",
                     cycle_cnt, accepted_cnt, result_cnt);
            $display("FAIL linked_queue_with_free_list");
            $finish;
        end
    end

    initial begin : stimulus
        logic [DATA_W-1:0] v;
        logic              f;
        int                enq_pct;
        int                run_len;
        int                n_random;
        clear_queue_shadow();

        // directed opening: empty and full corners, extremes, ignored values
        add_word(FUNC_DEQ, 32'hDEAD_BEEF, 1'b0);  // dequeue on an empty queue
        add_word(FUNC_ENQ, 32'h8000_0000, 1'b0);  // enqueue into empty queue
        add_word(FUNC_DEQ, 32'h7FFF_FFFF, 1'b0);  // dequeue the last element
        add_word(FUNC_ENQ, 32'h7FFF_FFFF, 1'b0);
        add_word(FUNC_ENQ, 32'hFFFF_FFFF, 1'b0);
        add_word(FUNC_ENQ, 32'h0000_0000, 1'b0);
        add_word(FUNC_ENQ, 32'h5555_5555, 1'b0);
        add_word(FUNC_ENQ, 32'hAAAA_AAAA, 1'b0);
        add_word(FUNC_ENQ, 32'h0000_0001, 1'b0);
        add_word(FUNC_ENQ, 32'h1234_5678, 1'b0);
        add_word(FUNC_ENQ, 32'h8000_0001, 1'b0);  // store now full
        add_word(FUNC_ENQ, 32'hCAFE_F00D, 1'b0);  // refused, value dropped
        for (int k = 0; k < NODES; k++)
            add_word(FUNC_DEQ, (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 1'b0);
        add_word(FUNC_DEQ, 32'h0F0F_0F0F, 1'b1);  // empty again, after a full drain
        add_word(FUNC_ENQ, 32'hFEDC_BA98, 1'b0);  // reuse of recycled nodes
        add_word(FUNC_DEQ, 32'h0000_0000, 1'b0);

        // random runs, biased towards filling, churning or draining
        n_random = 0;
        while (n_random < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            run_len = $urandom_range(8, 40);
            for (int k = 0; k < run_len; k++) begin
                f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
                case ($urandom_range(0, 11))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h0000_0000;
                    default: v = $urandom;
                endcase
                add_word(f, v, $urandom_range(0, 299) == 0);
                n_random++;
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold until every word is in and every result has been taken
        while (pending_words.size() > 0 || i_s_axis_tvalid || accepted_cnt != result_cnt)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (exp_results.size() != 0) begin
            fails += exp_results.size();
            $display("%0d expected results never arrived", exp_results.size());
        end

        $display("Ran %0d words: %0d enqueued, %0d dequeued, %0d refused full, %0d refused empty",
                 accepted_cnt, n_enq, n_deq, n_full, n_empty);
        $display("Checked %0d results through %0d long output stalls, %0d failures",
                 result_cnt, holds_done, fails);
        if (fails == 0)
            $display("PASS linked_queue_with_free_list");
        else
            $display("FAIL linked_queue_with_free_list");
        $finish;
    end

endmodule
